FILE: hdl/bgrt_pkg.sv
// Package for the BGR24 to RGB565 tiler: shared widths, register indexes
// and the command and status structs between controller and datapath.
// No dependencies.
package bgrt_pkg;

  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = 24;
  localparam int COLOR_W    = 16;
  localparam int OUT_W      = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int DIM_REG_W  = 13;
  localparam int TILE_REG_W = 9;
  localparam int PAD_W      = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PADDING  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // input byte transfer this cycle
    logic start;     // red byte taken, launch the address dividers
    logic mul_en;    // register the first products
    logic scale_en;  // register the tile base product
    logic load_out;  // load the output register
  } bgrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic red_next;  // next byte completes a pixel
    logic div_done;  // all dividers are idle
    logic out_free;  // output register can take a result
  } bgrt_sts_t;

endpackage

FILE: hdl/bgrt_div.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; used by the tiler datapath.
module bgrt_div #(
  parameter int N = 13,
  parameter int D = 9
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         busy,
  output logic [N-1:0] quotient,
  output logic [D-1:0] remainder
);

  localparam int CW = $clog2(N + 1);

  logic [CW-1:0] cnt;
  logic [D-1:0]  dsr;
  logic [D:0]    trial;
  logic          fits;

  // Shift the next dividend bit into the partial remainder.
  assign trial = {remainder, quotient[N-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign busy  = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(N);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Quotient bits replace dividend bits from the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[N-2:0], fits};
      remainder <= fits ? D'(trial - {1'b0, dsr}) : trial[D-1:0];
    end
  end

endmodule

FILE: hdl/bgrt_ctrl.sv
// Controller of the tiler: sequences the divide, multiply and output steps
// of one pixel and drives the input handshake. Depends on bgrt_pkg.
module bgrt_ctrl
  import bgrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bgrt_sts_t sts,
  output bgrt_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SCALE,
    ST_FIN
  } state_t;

  state_t state;

  // Bytes that do not finish a pixel are taken even while a pixel is in work.
  assign in_ready = (state == ST_IDLE) || !sts.red_next;

  always_comb begin
    cmd.accept   = in_valid && in_ready;
    cmd.start    = in_valid && in_ready && sts.red_next;
    cmd.mul_en   = state == ST_MUL;
    cmd.scale_en = state == ST_SCALE;
    cmd.load_out = (state == ST_FIN) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.start) state <= ST_DIV;
        end
        ST_DIV: begin
          if (sts.div_done) state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (sts.out_free) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/bgrt_dp.sv
// Datapath of the tiler: configuration registers, byte collection, frame
// counters, tile address arithmetic and the output register.
// Depends on bgrt_pkg and bgrt_div.
module bgrt_dp
  import bgrt_pkg::*;
#(
  parameter int MAX_DIM  = 4096,
  parameter int MAX_TILE = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [BYTE_W-1:0]     in_byte,
  input  bgrt_cmd_t             cmd,
  output bgrt_sts_t             sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_W-1:0]      out_data,
  output logic                  out_last
);

  // Largest usable dimensions, bounded by the register widths.
  localparam int DIM_LIM  = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
  localparam int TILE_LIM = (MAX_TILE > 511) ? 511 : MAX_TILE;
  localparam int DIV_W    = $clog2(DIM_LIM + 1);
  localparam int CNT_W    = $clog2(DIM_LIM);
  localparam int TW_W     = $clog2(TILE_LIM + 1);
  localparam logic [DIM_REG_W-1:0]  DIM_LIM_V  = DIM_REG_W'(DIM_LIM);
  localparam logic [TILE_REG_W-1:0] TILE_LIM_V = TILE_REG_W'(TILE_LIM);

  typedef enum logic [1:0] {
    PH_BLUE,
    PH_GREEN,
    PH_RED
  } phase_t;

  logic [DIM_REG_W-1:0]  image_width, image_height;
  logic [TILE_REG_W-1:0] tile_width, tile_height;
  logic [PAD_W-1:0]      row_padding;

  phase_t                byte_phase;
  logic [BYTE_W-1:0]     held_blue, held_green;
  logic [CNT_W-1:0]      column_count, row_count;
  logic [PAD_W-1:0]      pad_count;
  logic                  in_padding;

  logic [DIV_W-1:0]      w_c, h_c, x_ext, y_ext, x_inc, y_inc, yi;
  logic [TW_W-1:0]       tw_c, th_c;
  logic                  row_end, frame_end, pad_done, is_red;

  logic [COLOR_W-1:0]    color_hold;
  logic                  last_hold;

  logic [DIV_W-1:0]      q_x, q_y, q_w;
  logic [TW_W-1:0]       r_x, r_y, r_w;
  logic                  busy_x, busy_y, busy_w;

  logic [ADDR_W-1:0]     p_rows, p_in, tile_area, p_tile, addr_sum;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_REG_W'(1);
      image_height <= DIM_REG_W'(1);
      tile_width   <= TILE_REG_W'(1);
      tile_height  <= TILE_REG_W'(1);
      row_padding  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        CFG_TILE_WIDTH:   tile_width   <= cfg_data[TILE_REG_W-1:0];
        CFG_TILE_HEIGHT:  tile_height  <= cfg_data[TILE_REG_W-1:0];
        CFG_ROW_PADDING:  row_padding  <= cfg_data[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Dimensions in use: zero reads as one, large values saturate.
  always_comb begin
    if (image_width == '0)           w_c = DIV_W'(1);
    else if (image_width > DIM_LIM_V) w_c = DIV_W'(DIM_LIM);
    else                             w_c = DIV_W'(image_width);
    if (image_height == '0)           h_c = DIV_W'(1);
    else if (image_height > DIM_LIM_V) h_c = DIV_W'(DIM_LIM);
    else                              h_c = DIV_W'(image_height);
    if (tile_width == '0)             tw_c = TW_W'(1);
    else if (tile_width > TILE_LIM_V) tw_c = TW_W'(TILE_LIM);
    else                              tw_c = TW_W'(tile_width);
    if (tile_height == '0)             th_c = TW_W'(1);
    else if (tile_height > TILE_LIM_V) th_c = TW_W'(TILE_LIM);
    else                               th_c = TW_W'(tile_height);
  end

  // Row and frame ends, and the flipped row index.
  always_comb begin
    x_ext     = DIV_W'(column_count);
    y_ext     = DIV_W'(row_count);
    x_inc     = x_ext + 1'b1;
    y_inc     = y_ext + 1'b1;
    row_end   = x_inc >= w_c;
    frame_end = row_end && (y_inc >= h_c);
    yi        = (y_ext < h_c) ? DIV_W'(h_c - y_ext - 1'b1) : '0;
    pad_done  = ({1'b0, pad_count} + 1'b1) >= {1'b0, row_padding};
    is_red    = (byte_phase != PH_BLUE) && (byte_phase != PH_GREEN);
  end

  assign sts.red_next = !in_padding && is_red;
  assign sts.div_done = !busy_x && !busy_y && !busy_w;
  assign sts.out_free = !out_valid || out_ready;

  // Byte collection, padding skip and frame counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase   <= PH_BLUE;
      column_count <= '0;
      row_count    <= '0;
      pad_count    <= '0;
      in_padding   <= 1'b0;
    end else if (cmd.accept) begin
      if (in_padding) begin
        if (pad_done) begin
          in_padding <= 1'b0;
          pad_count  <= '0;
        end else begin
          pad_count <= pad_count + 1'b1;
        end
      end else if (byte_phase == PH_BLUE) begin
        byte_phase <= PH_GREEN;
      end else if (byte_phase == PH_GREEN) begin
        byte_phase <= PH_RED;
      end else begin
        byte_phase <= PH_BLUE;
        if (row_end) begin
          column_count <= '0;
          row_count    <= frame_end ? '0 : y_inc[CNT_W-1:0];
          if (row_padding != '0) begin
            in_padding <= 1'b1;
            pad_count  <= '0;
          end
        end else begin
          column_count <= x_inc[CNT_W-1:0];
        end
      end
    end
  end

  // Held color components and the packed pixel.
  always_ff @(posedge clk) begin
    if (cmd.accept && !in_padding) begin
      if (byte_phase == PH_BLUE) begin
        held_blue <= in_byte;
      end else if (byte_phase == PH_GREEN) begin
        held_green <= in_byte;
      end
    end
    if (cmd.start) begin
      color_hold <= {in_byte[7:3], held_green[7:2], held_blue[7:3]};
      last_hold  <= frame_end;
    end
  end

  // Column, row and tiles-per-row divisions run side by side.
  bgrt_div #(.N(DIV_W), .D(TW_W)) u_div_x (
    .clk(clk), .rst(rst), .start(cmd.start), .dividend(x_ext), .divisor(tw_c),
    .busy(busy_x), .quotient(q_x), .remainder(r_x)
  );

  bgrt_div #(.N(DIV_W), .D(TW_W)) u_div_y (
    .clk(clk), .rst(rst), .start(cmd.start), .dividend(yi), .divisor(th_c),
    .busy(busy_y), .quotient(q_y), .remainder(r_y)
  );

  bgrt_div #(.N(DIV_W), .D(TW_W)) u_div_w (
    .clk(clk), .rst(rst), .start(cmd.start), .dividend(w_c), .divisor(tw_c),
    .busy(busy_w), .quotient(q_w), .remainder(r_w)
  );

  // First products: tile row offset, offset inside the tile, tile area.
  // The remainder of the tiles-per-row division only matters as a check.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_rows    <= ADDR_W'(q_y) * ADDR_W'(q_w);
      p_in      <= ADDR_W'(r_y) * ADDR_W'(tw_c);
      tile_area <= ADDR_W'(tw_c) * ADDR_W'(th_c);
    end
  end

  // Base address of the tile, kept modulo 2^24.
  always_ff @(posedge clk) begin
    if (cmd.scale_en) begin
      p_tile <= (ADDR_W'(q_x) + p_rows) * tile_area;
    end
  end

  assign addr_sum = p_tile + p_in + ADDR_W'(r_x);

  // Output register: frees the input side while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {color_hold, addr_sum};
      out_last <= last_hold;
    end
  end

  // A divider remainder is always below its divisor.
  logic unused_ok;
  assign unused_ok = r_w < tw_c;

endmodule

FILE: hdl/bgr24_to_rgb565_tiler.sv
// BGR24 to RGB565 tiler, top level. Each red byte completes a pixel; its
// tile address comes from the bit-serial dividers, then the multiply and
// scale steps. Blue, green and padding bytes are taken at one per cycle,
// also while a pixel is in work; the next red byte waits until the last
// result is loaded. Reset is synchronous and clears configuration to width,
// height and tile sizes of one with no padding, and starts a new frame.
module bgr24_to_rgb565_tiler
  import bgrt_pkg::*;
#(
  parameter int MAX_DIM  = 4096,
  parameter int MAX_TILE = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,   // data_byte[7:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,   // tile_address[23:0], color565[39:24]
  output logic                  m_axis_tlast    // last_pixel
);

  bgrt_cmd_t cmd;
  bgrt_sts_t sts;

  bgrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bgrt_dp #(.MAX_DIM(MAX_DIM), .MAX_TILE(MAX_TILE)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  // Every red byte transfer launches an address computation.
  a_red_starts: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && sts.red_next) |-> cmd.start)
    else $error("red byte taken without starting a pixel");

  // The dividers are running in the cycle after a launch.
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !sts.div_done)
    else $error("dividers idle after a pixel launch");

  // A result never overwrites one that has not been transferred.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register loaded while holding a result");

endmodule
